@@ hw/rtl/skcht_pkg.sv @@
// Package for the string-key coalesced hash table.
// Holds sizes, command codes, payload structs and the sequencer state type.
// No dependencies.
package skcht_pkg;

  localparam int unsigned MAX_ENTRIES = 64;
  localparam int unsigned NAME_BYTES  = 48;

  localparam int unsigned IDX_W    = $clog2(MAX_ENTRIES);
  localparam int unsigned CNT_W    = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned LEN_W    = $clog2(NAME_BYTES + 1);
  localparam int unsigned KEY_AW   = $clog2(NAME_BYTES);
  localparam int unsigned NB_DEPTH = MAX_ENTRIES * NAME_BYTES;
  localparam int unsigned NB_AW    = $clog2(NB_DEPTH);
  localparam int unsigned SUM_W    = 14;
  localparam int unsigned DIV_CW   = $clog2(SUM_W);

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_BUILD  = 2'd1,
    CMD_LOOKUP = 2'd2
  } cmd_e;

  localparam logic RES_BUILD  = 1'b0;
  localparam logic RES_LOOKUP = 1'b1;

  typedef struct packed {
    logic [1:0]         command;
    logic [7:0]         data_byte;
    logic signed [31:0] service_number;
    logic               last_byte;
  } in_t;

  typedef struct packed {
    logic               result_kind;
    logic               found;
    logic signed [31:0] answer_number;
  } out_t;

  typedef struct packed {
    logic [LEN_W-1:0]   len;
    logic signed [31:0] num;
    logic [SUM_W-1:0]   sum;
  } ent_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_B_RD, ST_DIV_LD, ST_DIV, ST_B_PLACE, ST_B_FILL, ST_B_POP,
    ST_B_WINIT, ST_B_WALK, ST_B_WNEXT, ST_B_DONE, ST_L_START, ST_L_SLOT,
    ST_L_ENT, ST_L_LEN, ST_L_BYTE, ST_L_BCMP, ST_L_NEXT, ST_L_LINK,
    ST_L_HIT, ST_L_MISS
  } state_e;

endpackage

@@ hw/rtl/string_key_coalesced_hash_table.sv @@
// Top level of the string-key coalesced hash table: storage, sequencer, hash divider.
// Depends on skcht_pkg.
//
// Load and non-final key bytes are taken while idle and give no result. A build
// hashes each entry with one shared restoring modulo unit, scans the
// slots for free ones, and for each collided entry walks the links of its
// home chain; it ends with a one-cycle result strobe. A final key byte
// starts a lookup: unless no table is built, it hashes the key, then compares
// the key bytes with the entry of each chain slot in turn, then gives a
// one-cycle strobe. busy is high throughout;
// results are shown for one cycle on done_o and cannot be stalled.
module string_key_coalesced_hash_table (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  skcht_pkg::in_t        item_i,
  output logic                  done_o,
  output skcht_pkg::out_t       result_o,
  input  logic                  cfg_we_i,
  input  logic [6:0]            cfg_wdata_i
);

  localparam int unsigned IW = skcht_pkg::IDX_W;
  localparam int unsigned CW = skcht_pkg::CNT_W;

  skcht_pkg::state_e state_q, state_d;

  // memories
  logic [7:0]         nb_mem   [skcht_pkg::NB_DEPTH];
  skcht_pkg::ent_t    ent_mem  [skcht_pkg::MAX_ENTRIES];
  logic [IW-1:0]      home_mem [skcht_pkg::MAX_ENTRIES];
  logic [IW-1:0]      sent_mem [skcht_pkg::MAX_ENTRIES];
  logic [IW-1:0]      slink_mem[skcht_pkg::MAX_ENTRIES];
  logic [IW-1:0]      stk_mem  [skcht_pkg::MAX_ENTRIES];
  logic [7:0]         key_mem  [skcht_pkg::NAME_BYTES];

  logic nb_we, nb_re, ent_we, ent_re, home_we, home_re, sent_we, sent_re;
  logic slink_we, slink_re, stk_we, stk_re, key_we, key_re;
  logic [skcht_pkg::NB_AW-1:0]  nb_waddr, nb_raddr;
  logic [7:0]                   nb_wdata, nb_rd_q, key_rd_q;
  logic [IW-1:0]                ent_waddr, ent_raddr, home_waddr, home_raddr;
  logic [IW-1:0]                sent_waddr, sent_raddr, slink_waddr, slink_raddr;
  logic [IW-1:0]                stk_waddr, stk_raddr;
  logic [IW-1:0]                home_wdata, sent_wdata, slink_wdata, stk_wdata;
  logic [IW-1:0]                home_rd_q, sent_rd_q, slink_rd_q, stk_rd_q;
  logic [skcht_pkg::KEY_AW-1:0] key_waddr, key_raddr;
  skcht_pkg::ent_t              ent_wdata, ent_rd_q;

  // control and data registers
  logic [CW-1:0]     ec_q, ec_d, n_q, n_d, i_q, i_d, depth_q, depth_d, steps_q, steps_d;
  logic [CW-1:0]     ld_idx_q, ld_idx_d;
  logic [IW-1:0]     s_q, s_d, e_q, e_d;
  logic [skcht_pkg::LEN_W-1:0] j_q, j_d, key_len_q, key_len_d, ld_byte_q, ld_byte_d;
  logic [skcht_pkg::SUM_W-1:0] key_sum_q, key_sum_d, ld_sum_q, ld_sum_d, dvd_q, dvd_d;
  logic [CW:0]       rem_q, rem_d, rem_sh;
  logic [skcht_pkg::DIV_CW-1:0] dcnt_q, dcnt_d;
  logic              built_q, built_d, mode_q, mode_d, key_long_q, key_long_d;
  logic              done_q, done_d;
  logic [skcht_pkg::MAX_ENTRIES-1:0] used_q, used_d, lval_q, lval_d;
  skcht_pkg::out_t   res_q, res_d;

  logic          accept, div_last;
  logic [CW-1:0] n_sat;
  logic [skcht_pkg::LEN_W-1:0] ld_len_new;
  logic [skcht_pkg::SUM_W-1:0] ld_sum_new;

  assign accept   = start && !busy;
  assign busy     = (state_q != skcht_pkg::ST_IDLE);
  assign done_o   = done_q;
  assign result_o = res_q;
  assign div_last = (dcnt_q == skcht_pkg::DIV_CW'(skcht_pkg::SUM_W - 1));
  assign rem_sh   = {rem_q[CW-1:0], dvd_q[skcht_pkg::SUM_W-1]};
  assign n_sat    = (ec_q > CW'(skcht_pkg::MAX_ENTRIES)) ? CW'(skcht_pkg::MAX_ENTRIES) : ec_q;
  assign ld_len_new = (ld_byte_q < skcht_pkg::LEN_W'(skcht_pkg::NAME_BYTES)) ?
                      ld_byte_q + 1'b1 : ld_byte_q;
  assign ld_sum_new = (ld_byte_q < skcht_pkg::LEN_W'(skcht_pkg::NAME_BYTES)) ?
                      ld_sum_q + skcht_pkg::SUM_W'(item_i.data_byte) : ld_sum_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      skcht_pkg::ST_IDLE: begin
        if (accept) begin
          priority if (item_i.command == skcht_pkg::CMD_BUILD) begin
            state_d = (n_sat == '0) ? skcht_pkg::ST_B_DONE : skcht_pkg::ST_B_RD;
          end else if (item_i.command == skcht_pkg::CMD_LOOKUP && item_i.last_byte) begin
            state_d = skcht_pkg::ST_L_START;
          end else begin
            state_d = skcht_pkg::ST_IDLE;
          end
        end
      end
      skcht_pkg::ST_B_RD:   state_d = skcht_pkg::ST_DIV_LD;
      skcht_pkg::ST_DIV_LD: state_d = skcht_pkg::ST_DIV;
      skcht_pkg::ST_DIV: begin
        if (div_last) state_d = mode_q ? skcht_pkg::ST_L_SLOT : skcht_pkg::ST_B_PLACE;
      end
      skcht_pkg::ST_B_PLACE: begin
        state_d = (i_q == n_q - 1'b1) ? skcht_pkg::ST_B_FILL : skcht_pkg::ST_B_RD;
      end
      skcht_pkg::ST_B_FILL: begin
        priority if (i_q == n_q || depth_q == '0) state_d = skcht_pkg::ST_B_DONE;
        else if (used_q[i_q[IW-1:0]])             state_d = skcht_pkg::ST_B_FILL;
        else                                       state_d = skcht_pkg::ST_B_POP;
      end
      skcht_pkg::ST_B_POP:   state_d = skcht_pkg::ST_B_WINIT;
      skcht_pkg::ST_B_WINIT: state_d = skcht_pkg::ST_B_WALK;
      skcht_pkg::ST_B_WALK: begin
        state_d = (steps_q < n_q && lval_q[s_q]) ? skcht_pkg::ST_B_WNEXT : skcht_pkg::ST_B_FILL;
      end
      skcht_pkg::ST_B_WNEXT: state_d = skcht_pkg::ST_B_WALK;
      skcht_pkg::ST_B_DONE:  state_d = skcht_pkg::ST_IDLE;
      skcht_pkg::ST_L_START: state_d = built_q ? skcht_pkg::ST_DIV_LD : skcht_pkg::ST_L_MISS;
      skcht_pkg::ST_L_SLOT: begin
        state_d = (steps_q > n_q || !used_q[s_q]) ? skcht_pkg::ST_L_MISS : skcht_pkg::ST_L_ENT;
      end
      skcht_pkg::ST_L_ENT:   state_d = skcht_pkg::ST_L_LEN;
      skcht_pkg::ST_L_LEN: begin
        state_d = (key_long_q || ent_rd_q.len != key_len_q) ? skcht_pkg::ST_L_NEXT
                                                              : skcht_pkg::ST_L_BYTE;
      end
      skcht_pkg::ST_L_BYTE: begin
        state_d = (j_q == ent_rd_q.len) ? skcht_pkg::ST_L_HIT : skcht_pkg::ST_L_BCMP;
      end
      skcht_pkg::ST_L_BCMP: begin
        state_d = (nb_rd_q == key_rd_q) ? skcht_pkg::ST_L_BYTE : skcht_pkg::ST_L_NEXT;
      end
      skcht_pkg::ST_L_NEXT: state_d = lval_q[s_q] ? skcht_pkg::ST_L_LINK : skcht_pkg::ST_L_MISS;
      skcht_pkg::ST_L_LINK: begin
        state_d = (CW'(slink_rd_q) >= n_q) ? skcht_pkg::ST_L_MISS : skcht_pkg::ST_L_SLOT;
      end
      skcht_pkg::ST_L_HIT:  state_d = skcht_pkg::ST_IDLE;
      skcht_pkg::ST_L_MISS: state_d = skcht_pkg::ST_IDLE;
      default:              state_d = skcht_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    ec_d = ec_q;  n_d = n_q;  i_d = i_q;  depth_d = depth_q;  steps_d = steps_q;
    ld_idx_d = ld_idx_q;  ld_byte_d = ld_byte_q;  ld_sum_d = ld_sum_q;
    s_d = s_q;  e_d = e_q;  j_d = j_q;
    key_len_d = key_len_q;  key_sum_d = key_sum_q;  key_long_d = key_long_q;
    dvd_d = dvd_q;  rem_d = rem_q;  dcnt_d = dcnt_q;
    built_d = built_q;  mode_d = mode_q;
    used_d = used_q;  lval_d = lval_q;
    done_d = 1'b0;  res_d = res_q;

    nb_we = 1'b0;  nb_waddr = '0;  nb_wdata = item_i.data_byte;  nb_re = 1'b0;  nb_raddr = '0;
    ent_we = 1'b0;  ent_waddr = ld_idx_q[IW-1:0];  ent_re = 1'b0;  ent_raddr = '0;
    ent_wdata = '{len: ld_len_new, num: item_i.service_number, sum: ld_sum_new};
    home_we = 1'b0;  home_waddr = i_q[IW-1:0];  home_wdata = rem_q[IW-1:0];
    home_re = 1'b0;  home_raddr = stk_rd_q;
    sent_we = 1'b0;  sent_waddr = '0;  sent_wdata = '0;  sent_re = 1'b0;  sent_raddr = s_q;
    slink_we = 1'b0; slink_waddr = s_q; slink_wdata = i_q[IW-1:0];
    slink_re = 1'b0; slink_raddr = s_q;
    stk_we = 1'b0;  stk_waddr = depth_q[IW-1:0];  stk_wdata = i_q[IW-1:0];
    stk_re = 1'b0;  stk_raddr = '0;
    key_we = 1'b0;  key_waddr = key_len_q[skcht_pkg::KEY_AW-1:0];
    key_re = 1'b0;  key_raddr = j_q[skcht_pkg::KEY_AW-1:0];

    if (cfg_we_i) ec_d = cfg_wdata_i;

    unique case (state_q)
      skcht_pkg::ST_IDLE: begin
        if (accept) begin
          priority case (item_i.command)
            skcht_pkg::CMD_LOAD: begin
              if (ld_idx_q < CW'(skcht_pkg::MAX_ENTRIES)) begin
                built_d = 1'b0;
                if (ld_byte_q < skcht_pkg::LEN_W'(skcht_pkg::NAME_BYTES)) begin
                  nb_we    = 1'b1;
                  nb_waddr = skcht_pkg::NB_AW'(ld_idx_q) *
                             skcht_pkg::NB_AW'(skcht_pkg::NAME_BYTES) +
                             skcht_pkg::NB_AW'(ld_byte_q);
                end
                ld_byte_d = ld_len_new;
                ld_sum_d  = ld_sum_new;
                if (item_i.last_byte) begin
                  ent_we    = 1'b1;
                  ld_idx_d  = ld_idx_q + 1'b1;
                  ld_byte_d = '0;
                  ld_sum_d  = '0;
                end
              end
            end
            skcht_pkg::CMD_BUILD: begin
              used_d  = '0;
              lval_d  = '0;
              depth_d = '0;
              i_d     = '0;
              n_d     = n_sat;
              built_d = (n_sat != '0);
              mode_d  = 1'b0;
            end
            skcht_pkg::CMD_LOOKUP: begin
              if (key_len_q < skcht_pkg::LEN_W'(skcht_pkg::NAME_BYTES)) begin
                key_we    = 1'b1;
                key_len_d = key_len_q + 1'b1;
                key_sum_d = key_sum_q + skcht_pkg::SUM_W'(item_i.data_byte);
              end else begin
                key_long_d = 1'b1;
              end
              mode_d = 1'b1;
            end
            default: ;
          endcase
        end
      end
      skcht_pkg::ST_B_RD: begin
        ent_re    = 1'b1;
        ent_raddr = i_q[IW-1:0];
      end
      skcht_pkg::ST_DIV_LD: begin
        dvd_d  = mode_q ? key_sum_q : ent_rd_q.sum;
        rem_d  = '0;
        dcnt_d = '0;
      end
      skcht_pkg::ST_DIV: begin
        // restoring remainder, one dividend bit per cycle
        rem_d  = (rem_sh >= {1'b0, n_q}) ? rem_sh - {1'b0, n_q} : rem_sh;
        dvd_d  = {dvd_q[skcht_pkg::SUM_W-2:0], 1'b0};
        dcnt_d = dcnt_q + 1'b1;
        if (div_last && mode_q) begin
          s_d     = rem_d[IW-1:0];
          steps_d = '0;
        end
      end
      skcht_pkg::ST_B_PLACE: begin
        home_we = 1'b1;
        if (!used_q[rem_q[IW-1:0]]) begin
          used_d[rem_q[IW-1:0]] = 1'b1;
          sent_we    = 1'b1;
          sent_waddr = rem_q[IW-1:0];
          sent_wdata = i_q[IW-1:0];
        end else if (depth_q < CW'(skcht_pkg::MAX_ENTRIES)) begin
          stk_we  = 1'b1;
          depth_d = depth_q + 1'b1;
        end
        i_d = (i_q == n_q - 1'b1) ? '0 : i_q + 1'b1;
      end
      skcht_pkg::ST_B_FILL: begin
        if (i_q != n_q && depth_q != '0) begin
          if (used_q[i_q[IW-1:0]]) begin
            i_d = i_q + 1'b1;
          end else begin
            stk_re    = 1'b1;
            stk_raddr = IW'(depth_q - 1'b1);
            depth_d   = depth_q - 1'b1;
          end
        end
      end
      skcht_pkg::ST_B_POP: begin
        used_d[i_q[IW-1:0]] = 1'b1;
        sent_we    = 1'b1;
        sent_waddr = i_q[IW-1:0];
        sent_wdata = stk_rd_q;
        home_re    = 1'b1;
      end
      skcht_pkg::ST_B_WINIT: begin
        s_d     = home_rd_q;
        steps_d = '0;
      end
      skcht_pkg::ST_B_WALK: begin
        if (steps_q < n_q && lval_q[s_q]) begin
          slink_re = 1'b1;
        end else begin
          // tail reached: hang the new slot on it
          if (!lval_q[s_q] && s_q != i_q[IW-1:0]) begin
            lval_d[s_q] = 1'b1;
            slink_we    = 1'b1;
          end
          i_d = i_q + 1'b1;
        end
      end
      skcht_pkg::ST_B_WNEXT: begin
        s_d     = slink_rd_q;
        steps_d = steps_q + 1'b1;
      end
      skcht_pkg::ST_B_DONE: begin
        done_d = 1'b1;
        res_d  = '{result_kind: skcht_pkg::RES_BUILD, found: 1'b0, answer_number: '0};
      end
      skcht_pkg::ST_L_START: ;
      skcht_pkg::ST_L_SLOT: begin
        sent_re = 1'b1;
      end
      skcht_pkg::ST_L_ENT: begin
        e_d       = sent_rd_q;
        ent_re    = 1'b1;
        ent_raddr = sent_rd_q;
      end
      skcht_pkg::ST_L_LEN: begin
        j_d = '0;
      end
      skcht_pkg::ST_L_BYTE: begin
        if (j_q != ent_rd_q.len) begin
          nb_re    = 1'b1;
          nb_raddr = skcht_pkg::NB_AW'(e_q) * skcht_pkg::NB_AW'(skcht_pkg::NAME_BYTES) +
                     skcht_pkg::NB_AW'(j_q);
          key_re   = 1'b1;
        end
      end
      skcht_pkg::ST_L_BCMP: begin
        j_d = j_q + 1'b1;
      end
      skcht_pkg::ST_L_NEXT: begin
        slink_re = lval_q[s_q];
      end
      skcht_pkg::ST_L_LINK: begin
        s_d     = slink_rd_q;
        steps_d = steps_q + 1'b1;
      end
      skcht_pkg::ST_L_HIT: begin
        done_d     = 1'b1;
        res_d      = '{result_kind: skcht_pkg::RES_LOOKUP, found: 1'b1,
                       answer_number: ent_rd_q.num};
        key_len_d  = '0;
        key_sum_d  = '0;
        key_long_d = 1'b0;
      end
      skcht_pkg::ST_L_MISS: begin
        done_d     = 1'b1;
        res_d      = '{result_kind: skcht_pkg::RES_LOOKUP, found: 1'b0, answer_number: 32'sd1};
        key_len_d  = '0;
        key_sum_d  = '0;
        key_long_d = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= skcht_pkg::ST_IDLE;
      ec_q       <= '0;
      n_q        <= '0;
      i_q        <= '0;
      depth_q    <= '0;
      steps_q    <= '0;
      ld_idx_q   <= '0;
      ld_byte_q  <= '0;
      ld_sum_q   <= '0;
      key_len_q  <= '0;
      key_sum_q  <= '0;
      key_long_q <= 1'b0;
      built_q    <= 1'b0;
      mode_q     <= 1'b0;
      used_q     <= '0;
      lval_q     <= '0;
      done_q     <= 1'b0;
      dcnt_q     <= '0;
    end else begin
      state_q    <= state_d;
      ec_q       <= ec_d;
      n_q        <= n_d;
      i_q        <= i_d;
      depth_q    <= depth_d;
      steps_q    <= steps_d;
      ld_idx_q   <= ld_idx_d;
      ld_byte_q  <= ld_byte_d;
      ld_sum_q   <= ld_sum_d;
      key_len_q  <= key_len_d;
      key_sum_q  <= key_sum_d;
      key_long_q <= key_long_d;
      built_q    <= built_d;
      mode_q     <= mode_d;
      used_q     <= used_d;
      lval_q     <= lval_d;
      done_q     <= done_d;
      dcnt_q     <= dcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q   <= s_d;
    e_q   <= e_d;
    j_q   <= j_d;
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    res_q <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (nb_we)    nb_mem[nb_waddr]       <= nb_wdata;
    if (nb_re)    nb_rd_q                <= nb_mem[nb_raddr];
    if (ent_we)   ent_mem[ent_waddr]     <= ent_wdata;
    if (ent_re)   ent_rd_q               <= ent_mem[ent_raddr];
    if (home_we)  home_mem[home_waddr]   <= home_wdata;
    if (home_re)  home_rd_q              <= home_mem[home_raddr];
    if (sent_we)  sent_mem[sent_waddr]   <= sent_wdata;
    if (sent_re)  sent_rd_q              <= sent_mem[sent_raddr];
    if (slink_we) slink_mem[slink_waddr] <= slink_wdata;
    if (slink_re) slink_rd_q             <= slink_mem[slink_raddr];
    if (stk_we)   stk_mem[stk_waddr]     <= stk_wdata;
    if (stk_re)   stk_rd_q               <= stk_mem[stk_raddr];
    if (key_we)   key_mem[key_waddr]     <= item_i.data_byte;
    if (key_re)   key_rd_q               <= key_mem[key_raddr];
  end

  // a result strobe always follows a busy cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> $past(busy))
    else $error("result without preceding work");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    built_q |-> (n_q != '0 && n_q <= CW'(skcht_pkg::MAX_ENTRIES)))
    else $error("built table with bad slot count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= CW'(skcht_pkg::MAX_ENTRIES))
    else $error("conflict stack overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.result_kind == skcht_pkg::RES_BUILD) |-> !result_o.found)
    else $error("build result flagged found");

endmodule

@@ dv/skcht_checker.sv @@
// Checker for the string-key coalesced hash table: tracks the command and config channels,
// predicts each result from its own copy of the table and compares it with done_o/result_o.
// Depends on skcht_pkg.
module skcht_checker (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  input  logic            busy,
  input  skcht_pkg::in_t  item_i,
  input  logic            done_o,
  input  skcht_pkg::out_t result_o,
  input  logic            cfg_we_i,
  input  logic [6:0]      cfg_wdata_i,
  output int              mismatches_o,
  output int              outstanding_o
);

  localparam int MAXE = skcht_pkg::MAX_ENTRIES;
  localparam int NB   = skcht_pkg::NAME_BYTES;

  logic [7:0]  name_mem [MAXE][NB];
  int          name_len [MAXE];
  logic [31:0] name_num [MAXE];
  int          name_sum [MAXE];
  int          slot_ent [MAXE];
  bit          slot_used[MAXE];
  int          slot_next[MAXE];
  bit          next_ok  [MAXE];
  int          spill    [MAXE];
  logic [7:0]  key_mem  [NB];
  int          key_len, key_sum;
  bit          key_long;
  int          ld_ent, ld_byte, ld_sum;
  bit          built;
  int          built_n;
  logic [6:0]  entry_count;
  skcht_pkg::out_t answers_q[$];

  assign outstanding_o = answers_q.size();

  task automatic build_table();
    int n, i, h, e, s, steps, depth;
    n = (entry_count > MAXE) ? MAXE : int'(entry_count);
    for (i = 0; i < MAXE; i++) begin
      slot_used[i] = 1'b0; next_ok[i] = 1'b0; slot_ent[i] = 0; slot_next[i] = 0;
    end
    depth = 0;
    built_n = n;
    built = (n != 0);
    if (n == 0) return;
    for (i = 0; i < n; i++) begin
      h = name_sum[i] % n;
      if (!slot_used[h]) begin
        slot_used[h] = 1'b1; slot_ent[h] = i;
      end else if (depth < MAXE) begin
        spill[depth] = i; depth++;
      end
    end
    // collided entries fill free slots low to high, appended at chain tail
    for (i = 0; i < n && depth != 0; i++) begin
      if (slot_used[i]) continue;
      depth--;
      e = spill[depth];
      h = name_sum[e] % n;
      slot_used[i] = 1'b1; slot_ent[i] = e;
      s = h;
      for (steps = 0; steps < n && next_ok[s]; steps++) s = slot_next[s];
      if (!next_ok[s] && s != i) begin
        next_ok[s] = 1'b1; slot_next[s] = i;
      end
    end
  endtask

  function automatic bit key_hits(int e);
    if (key_long || e >= MAXE || name_len[e] != key_len) return 1'b0;
    for (int j = 0; j < key_len; j++)
      if (name_mem[e][j] != key_mem[j]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic find_key(output bit hit, output logic [31:0] num);
    int s, steps;
    hit = 1'b0; num = 32'd1;
    if (!built || built_n == 0) return;
    s = key_sum % built_n;
    for (steps = 0; steps <= built_n; steps++) begin
      if (!slot_used[s]) return;
      if (key_hits(slot_ent[s])) begin
        hit = 1'b1; num = name_num[slot_ent[s]];
        return;
      end
      if (!next_ok[s] || slot_next[s] >= built_n) return;
      s = slot_next[s];
    end
  endtask

  task automatic take_item(skcht_pkg::in_t it);
    skcht_pkg::out_t r;
    bit              hit;
    logic [31:0]     num;
    case (it.command)
      skcht_pkg::CMD_LOAD: if (ld_ent < MAXE) begin
        built = 1'b0;
        if (ld_byte < NB) begin
          name_mem[ld_ent][ld_byte] = it.data_byte;
          ld_byte++;
          ld_sum += it.data_byte;
        end
        if (it.last_byte) begin
          name_len[ld_ent] = ld_byte;
          name_num[ld_ent] = it.service_number;
          name_sum[ld_ent] = ld_sum;
          ld_ent++; ld_byte = 0; ld_sum = 0;
        end
      end
      skcht_pkg::CMD_BUILD: begin
        build_table();
        r.result_kind = skcht_pkg::RES_BUILD; r.found = 1'b0; r.answer_number = '0;
        answers_q.push_back(r);
      end
      skcht_pkg::CMD_LOOKUP: begin
        if (key_len < NB) begin
          key_mem[key_len] = it.data_byte;
          key_len++;
          key_sum += it.data_byte;
        end else key_long = 1'b1;
        if (it.last_byte) begin
          find_key(hit, num);
          key_len = 0; key_sum = 0; key_long = 1'b0;
          r.result_kind = skcht_pkg::RES_LOOKUP; r.found = hit; r.answer_number = num;
          answers_q.push_back(r);
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    skcht_pkg::out_t want;
    if (!rst_ni) begin
      answers_q.delete();
      mismatches_o = 0;
      key_len = 0; key_sum = 0; key_long = 1'b0;
      ld_ent = 0; ld_byte = 0; ld_sum = 0;
      built = 1'b0; built_n = 0; entry_count = '0;
      for (int i = 0; i < MAXE; i++) begin
        slot_used[i] = 1'b0; next_ok[i] = 1'b0;
      end
    end else begin
      if (done_o) begin
        if (answers_q.size() == 0) begin
          $display("%0t: unexpected result %p", $time, result_o);
          mismatches_o++;
        end else begin
          want = answers_q.pop_front();
          if (want.result_kind !== result_o.result_kind ||
              want.found !== result_o.found ||
              want.answer_number !== result_o.answer_number) begin
            $display("%0t: result mismatch expected kind=%0d found=%0d num=%0d, got kind=%0d found=%0d num=%0d",
                     $time, want.result_kind, want.found, want.answer_number,
                     result_o.result_kind, result_o.found, result_o.answer_number);
            mismatches_o++;
          end
        end
      end
      if (start && !busy) take_item(item_i);
      if (cfg_we_i) entry_count = cfg_wdata_i;
    end
  end
endmodule

@@ dv/tb_string_key_coalesced_hash_table.sv @@
// Testbench top for the string-key coalesced hash table: drives name loads, builds and
// lookups with random gaps and config changes. Depends on skcht_pkg and skcht_checker.
module tb_string_key_coalesced_hash_table;

  localparam logic [1:0] CMD_NOP = 2'd3;
  localparam int LIMIT = 3000000;
  localparam int ITEM_GOAL = 1100;

  logic            clk_i = 0;
  logic            rst_ni = 0;
  logic            start = 0;
  logic            busy;
  skcht_pkg::in_t  item_i = '0;
  logic            done_o;
  skcht_pkg::out_t result_o;
  logic            cfg_we_i = 0;
  logic [6:0]      cfg_wdata_i = '0;
  int              mismatches, outstanding;

  int          cycles = 0;
  int          items = 0;
  int          loaded = 0;
  bit          no_gaps = 0;
  logic [7:0]  names[64][52];
  int          name_sz[64];

  always #5 clk_i = ~clk_i;

  string_key_coalesced_hash_table dut (
    .clk_i, .rst_ni, .start, .busy, .item_i, .done_o, .result_o, .cfg_we_i, .cfg_wdata_i
  );

  skcht_checker u_checker (
    .clk_i, .rst_ni, .start, .busy, .item_i, .done_o, .result_o, .cfg_we_i, .cfg_wdata_i,
    .mismatches_o(mismatches), .outstanding_o(outstanding)
  );

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send(logic [1:0] cmd, logic [7:0] b, logic [31:0] num, logic last,
                      bit counts);
    int g;
    start <= 1'b1;
    item_i <= '{command: cmd, data_byte: b, service_number: num, last_byte: last};
    do @(posedge clk_i); while (busy);
    if (counts) items++;
    g = pick_gap();
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  // hold off until every result is in and the block is idle
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0 || busy);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_count(logic [6:0] v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_name(logic [7:0] b[52], int len, logic [31:0] num);
    bit counts;
    counts = loaded < 64;
    for (int j = 0; j < len; j++) send(skcht_pkg::CMD_LOAD, b[j], num, j == len - 1, counts);
    if (counts) begin
      names[loaded] = b;
      name_sz[loaded] = len;
      loaded++;
    end
  endtask

  task automatic load_random_name();
    logic [7:0] b[52];
    int len;
    len = ($urandom_range(0, 99) < 4) ? $urandom_range(46, 52) : $urandom_range(1, 6);
    for (int j = 0; j < 52; j++)
      b[j] = ($urandom_range(0, 9) < 8) ? 8'(8'h61 + $urandom_range(0, 3))
                                         : 8'($urandom_range(0, 255));
    load_name(b, len, $urandom);
  endtask

  task automatic lookup(logic [7:0] b[52], int len);
    for (int j = 0; j < len; j++)
      send(skcht_pkg::CMD_LOOKUP, b[j], $urandom, j == len - 1, 1'b1);
  endtask

  task automatic lookup_random();
    logic [7:0] b[52];
    int len, r, e;
    r = $urandom_range(0, 99);
    for (int j = 0; j < 52; j++)
      b[j] = ($urandom_range(0, 9) < 8) ? 8'(8'h61 + $urandom_range(0, 3))
                                         : 8'($urandom_range(0, 255));
    len = $urandom_range(1, 6);
    if (loaded > 0 && r < 75) begin
      e = $urandom_range(0, loaded - 1);
      b = names[e];
      len = name_sz[e];
      if (len > 48 && $urandom_range(0, 1)) len = 48;
      if (r >= 60) begin
        if (len > 1 && $urandom_range(0, 1)) len--;
        else b[$urandom_range(0, len - 1)] ^= 8'h01 << $urandom_range(0, 7);
      end
    end
    lookup(b, len);
  endtask

  initial begin
    logic [7:0] b[52];
    int k, n, c;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table: no build yet, then a build with the reset count of zero
    b[0] = 8'h61;
    lookup(b, 1);
    send(skcht_pkg::CMD_BUILD, 8'h00, 32'd0, 1'b0, 1'b1);
    lookup(b, 1);
    write_count(7'd0);
    send(skcht_pkg::CMD_BUILD, 8'hff, 32'hffffffff, 1'b1, 1'b1);
    // zero byte, all-ones byte, two-byte name with same sum as a neighbor
    b[0] = 8'h00; load_name(b, 1, 32'h7fffffff);
    b[0] = 8'hff; load_name(b, 1, 32'h80000000);
    b[0] = 8'h7f; b[1] = 8'h80; load_name(b, 2, 32'hffffffff);
    b[0] = 8'h00; lookup(b, 1);              // loaded since build: miss
    write_count(7'd3);
    send(skcht_pkg::CMD_BUILD, 8'h00, 32'd0, 1'b0, 1'b1);
    b[0] = 8'h00; lookup(b, 1);
    b[0] = 8'hff; lookup(b, 1);
    b[0] = 8'h7f; b[1] = 8'h80; lookup(b, 2);
    b[0] = 8'h80; b[1] = 8'h7f; lookup(b, 2);  // same sum, different string
    send(CMD_NOP, 8'h00, 32'd0, 1'b1, 1'b0);
    write_count(7'd1);                       // no effect until rebuilt
    b[0] = 8'hff; lookup(b, 1);
    send(skcht_pkg::CMD_BUILD, 8'h00, 32'd0, 1'b0, 1'b1);
    b[0] = 8'hff; lookup(b, 1);
    b[0] = 8'h00; lookup(b, 1);

    while (items < ITEM_GOAL) begin
      no_gaps = ($urandom_range(0, 9) < 3);
      k = $urandom_range(1, 6);
      if (loaded >= 64) k = $urandom_range(0, 1);
      for (int i = 0; i < k; i++) load_random_name();
      if ($urandom_range(0, 4) == 0) lookup_random();
      c = $urandom_range(0, 99);
      if (loaded == 64 && c < 25) n = 127;
      else if (c < 50) n = loaded;
      else if (c < 60) n = 1;
      else n = $urandom_range(1, loaded);
      write_count(n[6:0]);
      send(skcht_pkg::CMD_BUILD, 8'($urandom), $urandom, 1'($urandom_range(0, 1)), 1'b1);
      n = $urandom_range(8, 20);
      for (int i = 0; i < n; i++) begin
        lookup_random();
        if ($urandom_range(0, 29) == 0) send(CMD_NOP, 8'($urandom), $urandom, 1'b1, 1'b0);
        if (i == n / 2 && $urandom_range(0, 4) == 0)
          write_count(7'($urandom_range(1, loaded)));
      end
    end

    drain();
    repeat (100) @(posedge clk_i);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

@@ files.f @@
hw/rtl/skcht_pkg.sv
hw/rtl/string_key_coalesced_hash_table.sv
dv/skcht_checker.sv
dv/tb_string_key_coalesced_hash_table.sv
